// File: hw/rtl/rle_pkg.sv
package rle_pkg;

	// message opcodes on the input side, message types on the output side
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_M1    = 2'd1;
	localparam logic [1:0] OP_M2    = 2'd2;
	localparam logic [1:0] OP_ELECT = 2'd3;

	localparam logic [1:0] MSG_NONE  = 2'd0;
	localparam logic [1:0] MSG_M1    = 2'd1;
	localparam logic [1:0] MSG_M2    = 2'd2;
	localparam logic [1:0] MSG_ELECT = 2'd3;

	// node modes
	localparam logic [1:0] MODE_ACTIVE  = 2'd0;
	localparam logic [1:0] MODE_WAITING = 2'd1;
	localparam logic [1:0] MODE_PASSIVE = 2'd2;
	localparam logic [1:0] MODE_DONE    = 2'd3;

	// field widths
	localparam int PID_W   = 16;
	localparam int PHASE_W = 4;
	localparam int CNT_W   = 16;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [1:0]         op;
		logic [PID_W-1:0]   msg_pid;
		logic [PHASE_W-1:0] msg_phase;
		logic [CNT_W-1:0]   msg_counter;
	} item_t;

	typedef struct packed {
		logic               send_valid;
		logic [1:0]         send_type;
		logic [PID_W-1:0]   send_pid;
		logic [PHASE_W-1:0] send_phase;
		logic [CNT_W-1:0]   send_counter;
		logic               is_leader;
		logic               finished;
		logic               protocol_error;
	} result_t;

	// classified message handed from front to back
	typedef struct packed {
		logic [1:0]         op;
		logic               own;
		logic [PID_W-1:0]   pid;
		logic [PHASE_W-1:0] phase;
		logic [CNT_W-1:0]   counter;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// File: hw/rtl/rle_front.sv
module rle_front import rle_pkg::*; #(
	parameter int ID_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	input  logic [PID_W-1:0] node_id,
	input  q_status_t        q_status,
	output logic             push,
	output cmd_t             push_cmd
);

	localparam int IdW = (ID_BITS < PID_W) ? ID_BITS : PID_W;
	localparam logic [PID_W-1:0] IdMask = PID_W'((17'(1) << IdW) - 17'(1));

	logic       valid_s1;
	cmd_t       cmd_s1;
	cmd_t       cmd_d;
	logic       accept;
	logic [PID_W-1:0] pid_m;

	// classify the incoming message
	always_comb begin
		pid_m          = item.msg_pid & IdMask;
		cmd_d.op       = item.op;
		cmd_d.pid      = pid_m;
		cmd_d.own      = (pid_m == (node_id & IdMask));
		cmd_d.phase    = item.msg_phase;
		cmd_d.counter  = item.msg_counter;
	end

	// handshake toward the queue
	assign push       = valid_s1 && !q_status.full;
	assign item_stall = valid_s1 && q_status.full;
	assign accept     = item_valid && !item_stall;
	assign push_cmd   = cmd_s1;

	// front stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

// File: hw/rtl/rle_queue.sv
module rle_queue import rle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      pop_cmd,
	output q_status_t q_status
);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign pop_cmd        = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: hw/rtl/rle_back.sv
module rle_back import rle_pkg::*; #(
	parameter int ID_BITS    = 16,
	parameter int PHASE_BITS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [PID_W-1:0] node_id,
	input  q_status_t        q_status,
	output logic             pop,
	input  cmd_t             pop_cmd,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result
);

	localparam int IdW = (ID_BITS < PID_W) ? ID_BITS : PID_W;
	localparam logic [PHASE_BITS-1:0] PhaseMax = '1;

	logic [1:0]            mode_q;
	logic [IdW-1:0]        best_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic                  res_valid_q;
	result_t               res_q;

	logic [1:0]            mode_d;
	logic [IdW-1:0]        best_d;
	logic [PHASE_BITS-1:0] phase_d;
	result_t               res_d;

	logic [IdW-1:0]        me;
	logic [IdW-1:0]        pid;
	logic [PHASE_BITS-1:0] ph_inc;
	logic [PHASE_BITS-1:0] mph_sat;
	logic [CNT_W-1:0]      cnt_new;

	assign me  = node_id[IdW-1:0];
	assign pid = pop_cmd.pid[IdW-1:0];

	// phase arithmetic
	always_comb begin
		ph_inc  = (phase_q == PhaseMax) ? phase_q : phase_q + 1'b1;
		mph_sat = (6'(pop_cmd.phase) > 6'(PhaseMax)) ? PhaseMax
			: PHASE_BITS'(pop_cmd.phase);
		cnt_new = (6'(ph_inc) >= 6'd16) ? {CNT_W{1'b1}} : (CNT_W'(1) << ph_inc);
	end

	// execute one message against the node state
	always_comb begin
		mode_d  = mode_q;
		best_d  = best_q;
		phase_d = phase_q;
		res_d   = '0;
		if (mode_q == MODE_DONE) begin
			res_d.finished = 1'b1;
		end else if (pop_cmd.op == OP_START) begin
			best_d             = me;
			phase_d            = '0;
			mode_d             = MODE_ACTIVE;
			res_d.send_valid   = 1'b1;
			res_d.send_type    = MSG_M1;
			res_d.send_pid     = PID_W'(me);
			res_d.send_counter = CNT_W'(1);
		end else if (pop_cmd.op == OP_ELECT) begin
			mode_d           = MODE_DONE;
			res_d.send_valid = 1'b1;
			res_d.send_type  = MSG_ELECT;
			res_d.send_pid   = PID_W'(pid);
			res_d.is_leader  = pop_cmd.own;
			res_d.finished   = 1'b1;
		end else if (pop_cmd.own) begin
			// own id came back around the ring
			res_d.send_valid = 1'b1;
			res_d.send_type  = MSG_ELECT;
			res_d.send_pid   = PID_W'(me);
		end else if (mode_q == MODE_ACTIVE) begin
			if (pop_cmd.op != OP_M1) begin
				res_d.protocol_error = 1'b1;
			end else if (pid > best_q) begin
				best_d = pid;
				mode_d = MODE_WAITING;
			end else begin
				mode_d           = MODE_PASSIVE;
				res_d.send_valid = 1'b1;
				res_d.send_type  = MSG_M2;
				res_d.send_pid   = PID_W'(best_q);
			end
		end else if (mode_q == MODE_WAITING && pop_cmd.op == OP_M2) begin
			res_d.protocol_error = (pid != best_q);
			phase_d              = ph_inc;
			mode_d               = MODE_ACTIVE;
			res_d.send_valid     = 1'b1;
			res_d.send_type      = MSG_M1;
			res_d.send_pid       = PID_W'(best_q);
			res_d.send_phase     = PHASE_W'(ph_inc);
			res_d.send_counter   = cnt_new;
		end else begin
			// passive relay, a waiting node drops to passive first
			mode_d = MODE_PASSIVE;
			if (pop_cmd.op == OP_M1) begin
				res_d.send_valid = 1'b1;
				res_d.send_type  = MSG_M1;
				res_d.send_pid   = PID_W'(pid);
				res_d.send_phase = pop_cmd.phase;
				if (pid >= best_q && pop_cmd.counter != '0) begin
					best_d = pid;
					if (pop_cmd.counter > CNT_W'(1)) begin
						res_d.send_counter = pop_cmd.counter - 1'b1;
					end else begin
						mode_d  = MODE_WAITING;
						phase_d = mph_sat;
					end
				end
			end else if (pid >= best_q) begin
				res_d.send_valid = 1'b1;
				res_d.send_type  = MSG_M2;
				res_d.send_pid   = PID_W'(pid);
			end
		end
	end

	// take a queued message whenever the output register frees up
	assign pop          = !q_status.empty && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// node state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_ACTIVE;
			best_q      <= '0;
			phase_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (pop) begin
			mode_q      <= mode_d;
			best_q      <= best_d;
			phase_q     <= phase_d;
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule

// File: hw/rtl/ring_leader_election_node.sv
// channel  | signals                      | direction | beat when
// ---------+------------------------------+-----------+---------------------------
// item     | item_valid, item_stall, item | in        | item_valid && !item_stall
// result   | result_valid, result_stall,  | out       | result_valid && !result_stall
//          | result                       |           |
// cfg      | cfg_valid, cfg_ready,        | in        | cfg_valid && cfg_ready
//          | cfg_data (node id)           |           |
//
// one item per cycle while result_stall is low; a result passes the front stage
// register, a queue entry and the output register, loaded along with the node state
// a 2-entry queue lets the front keep taking items while the result side stalls
// arst_n clears the node to active mode with best id, phase and node id at zero
// cfg is always ready and must be written while no item is in flight (not enforced)
module ring_leader_election_node import rle_pkg::*; #(
	parameter int ID_BITS    = 16,
	parameter int PHASE_BITS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [PID_W-1:0] cfg_data
);

	logic [PID_W-1:0] node_id_q;
	q_status_t        q_status;
	logic             push;
	logic             pop;
	cmd_t             push_cmd;
	cmd_t             pop_cmd;

	// node id register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			node_id_q <= cfg_data;
		end
	end

	// accept and classify
	rle_front #(
		.ID_BITS (ID_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.node_id    (node_id_q),
		.q_status   (q_status),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// decoupling queue
	rle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.q_status (q_status)
	);

	// protocol execution
	rle_back #(
		.ID_BITS    (ID_BITS),
		.PHASE_BITS (PHASE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.node_id      (node_id_q),
		.q_status     (q_status),
		.pop          (pop),
		.pop_cmd      (pop_cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: hw/rtl/rle_checker.sv
module rle_checker import rle_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	logic done_seen_q;

	// remember that an election result has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (result_valid && !result_stall && result.finished) begin
			done_seen_q <= 1'b1;
		end
	end

	// a stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// once finished, every later beat reports finished and sends nothing
	a_finished_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && done_seen_q |-> result.finished && !result.send_valid)
		else $error("beat after election not marked finished");

	// leader flag only rides on an outgoing elect message
	a_leader_elect: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_leader |->
			result.send_valid && result.send_type == MSG_ELECT && result.finished)
		else $error("leader flag without elect message");

	// no message means an all-zero message payload
	a_idle_payload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.send_valid |->
			result.send_type == MSG_NONE && result.send_pid == '0 &&
			result.send_phase == '0 && result.send_counter == '0)
		else $error("message fields set with no message sent");

endmodule

bind ring_leader_election_node rle_checker u_rle_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
